// File: rtl/u2g_pkg.sv
// Shared types, code constants and lookup functions of the UTF-8 to GSM 7-bit encoder.
package u2g_pkg;

   localparam int CodeW = 7;

   localparam logic [CodeW-1:0] CODE_ESC   = 7'h1B;
   localparam logic [CodeW-1:0] CODE_QMARK = 7'h3F;
   localparam logic [CodeW-1:0] CODE_AT    = 7'h00;
   localparam logic [CodeW-1:0] CODE_DOLLAR = 7'h02;
   localparam logic [CodeW-1:0] CODE_UNDERSCORE = 7'h11;
   localparam logic [CodeW-1:0] CODE_EURO  = 7'h65;

   localparam logic [7:0] BYTE_CTRL_TOP = 8'h1F;
   localparam logic [7:0] BYTE_GRP_MIN  = 8'h7F;

   localparam logic [2:0] GRP_NONE  = 3'd0;
   localparam logic [2:0] GRP_TWO   = 3'd2;
   localparam logic [2:0] GRP_THREE = 3'd3;
   localparam logic [2:0] GRP_FOUR  = 3'd4;

   localparam logic [23:0] EURO_KEY = 24'hE282AC;

   // Codes produced by one input word: count 0..2, first code goes out first.
   typedef struct packed {
      logic [1:0]       cnt;
      logic [CodeW-1:0] code0;
      logic [CodeW-1:0] code1;
   } codes_type;

   typedef struct packed {
      logic             hit;
      logic [CodeW-1:0] code;
   } lookup_type;

   // Two-byte group table (Latin and Greek letters and some symbols).
   function automatic lookup_type lookup_two(input logic [15:0] key);
      lookup_type r;
      r.hit  = 1'b1;
      r.code = CODE_QMARK;
      case (key)
         16'hC2A3: r.code = 7'h01;
         16'hC2A5: r.code = 7'h03;
         16'hC3A8: r.code = 7'h04;
         16'hC3A9: r.code = 7'h05;
         16'hC3B9: r.code = 7'h06;
         16'hC3AC: r.code = 7'h07;
         16'hC3B2: r.code = 7'h08;
         16'hC387: r.code = 7'h09;
         16'hC398: r.code = 7'h0B;
         16'hC3B8: r.code = 7'h0C;
         16'hC385: r.code = 7'h0E;
         16'hC3A5: r.code = 7'h0F;
         16'hCE94: r.code = 7'h10;
         16'hCEA6: r.code = 7'h12;
         16'hCE93: r.code = 7'h13;
         16'hCE9B: r.code = 7'h14;
         16'hCEA9: r.code = 7'h15;
         16'hCEA0: r.code = 7'h16;
         16'hCEA8: r.code = 7'h17;
         16'hCEA3: r.code = 7'h18;
         16'hCE98: r.code = 7'h19;
         16'hCE9E: r.code = 7'h1A;
         16'hC386: r.code = 7'h1C;
         16'hC3A6: r.code = 7'h1D;
         16'hC39F: r.code = 7'h1E;
         16'hC389: r.code = 7'h1F;
         16'hC2A4: r.code = 7'h24;
         16'hC384: r.code = 7'h5B;
         16'hC396: r.code = 7'h5C;
         16'hC391: r.code = 7'h5D;
         16'hC39C: r.code = 7'h5E;
         16'hC2A7: r.code = 7'h5F;
         16'hC2BF: r.code = 7'h60;
         16'hC3A4: r.code = 7'h7B;
         16'hC3B6: r.code = 7'h7C;
         16'hC3B1: r.code = 7'h7D;
         16'hC3BC: r.code = 7'h7E;
         16'hC3A0: r.code = 7'h7F;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

   // Map a byte below 0x7F to zero, one or two codes.
   function automatic codes_type map_single(input logic [7:0] b);
      codes_type r;
      r.cnt   = 2'd1;
      r.code0 = b[CodeW-1:0];
      r.code1 = '0;
      case (b) inside
         [8'h00:BYTE_CTRL_TOP]: r.cnt = 2'd0;
         8'h40: r.code0 = CODE_AT;
         8'h60: r.code0 = CODE_QMARK;
         8'h24: r.code0 = CODE_DOLLAR;
         8'h5F: r.code0 = CODE_UNDERSCORE;
         8'h5B: begin r.cnt = 2'd2; r.code0 = CODE_ESC; r.code1 = 7'h3C; end
         8'h5C: begin r.cnt = 2'd2; r.code0 = CODE_ESC; r.code1 = 7'h2F; end
         8'h5D: begin r.cnt = 2'd2; r.code0 = CODE_ESC; r.code1 = 7'h3E; end
         8'h5E: begin r.cnt = 2'd2; r.code0 = CODE_ESC; r.code1 = 7'h14; end
         8'h7B: begin r.cnt = 2'd2; r.code0 = CODE_ESC; r.code1 = 7'h28; end
         8'h7C: begin r.cnt = 2'd2; r.code0 = CODE_ESC; r.code1 = 7'h40; end
         8'h7D: begin r.cnt = 2'd2; r.code0 = CODE_ESC; r.code1 = 7'h29; end
         8'h7E: begin r.cnt = 2'd2; r.code0 = CODE_ESC; r.code1 = 7'h3D; end
         default: r.cnt = 2'd1;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/u2g_map.sv
// Group tracking state and byte-to-code mapping of the encoder.
module u2g_map import u2g_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output codes_type  codes
);

   logic [15:0] grp_bytes_ff, grp_bytes_in;
   logic [2:0]  grp_len_ff, grp_len_in;
   logic [1:0]  due_ff, due_in;
   logic [23:0] key;
   lookup_type  two_hit;

   assign key     = {grp_bytes_ff, in_byte};
   assign two_hit = lookup_two(key[15:0]);

   always_comb begin
      codes        = '0;
      grp_bytes_in = grp_bytes_ff;
      grp_len_in   = grp_len_ff;
      due_in       = due_ff;
      if (grp_len_ff != GRP_NONE) begin
         if (due_ff <= 2'd1) begin
            // group complete: look it up and close it
            codes.cnt   = 2'd1;
            codes.code0 = CODE_QMARK;
            if (grp_len_ff == GRP_TWO && two_hit.hit) begin
               codes.code0 = two_hit.code;
            end else if (grp_len_ff == GRP_THREE && key == EURO_KEY) begin
               codes.cnt   = 2'd2;
               codes.code0 = CODE_ESC;
               codes.code1 = CODE_EURO;
            end
            grp_bytes_in = '0;
            grp_len_in   = GRP_NONE;
            due_in       = '0;
         end else begin
            grp_bytes_in = key[15:0];
            due_in       = due_ff - 2'd1;
            if (in_last) begin
               codes.cnt   = 2'd1;
               codes.code0 = CODE_QMARK;
            end
         end
      end else if (in_byte >= BYTE_GRP_MIN) begin
         case (in_byte) inside
            [8'hC0:8'hDF]: grp_len_in = GRP_TWO;
            [8'hE0:8'hEF]: grp_len_in = GRP_THREE;
            default:       grp_len_in = GRP_FOUR;
         endcase
         grp_bytes_in = {8'h00, in_byte};
         due_in       = 2'(grp_len_in - 3'd1);
         if (in_last) begin
            codes.cnt   = 2'd1;
            codes.code0 = CODE_QMARK;
         end
      end else begin
         codes = map_single(in_byte);
      end
      // end of message closes any group
      if (in_last) begin
         grp_bytes_in = '0;
         grp_len_in   = GRP_NONE;
         due_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_bytes_ff <= '0;
         grp_len_ff   <= GRP_NONE;
         due_ff       <= '0;
      end else if (step) begin
         grp_bytes_ff <= grp_bytes_in;
         grp_len_ff   <= grp_len_in;
         due_ff       <= due_in;
      end
   end

endmodule

// File: rtl/u2g_outbuf.sv
// Result register of the encoder: holds up to two codes and sends them one per word.
module u2g_outbuf import u2g_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  codes_type        codes,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [CodeW-1:0] rsp_out_code,
   output logic             rsp_out_run_last
);

   logic [1:0]       cnt_ff;
   logic [CodeW-1:0] code0_ff;
   logic [CodeW-1:0] code1_ff;
   logic             take;

   assign rsp_valid        = cnt_ff != 2'd0;
   assign take             = rsp_valid && rsp_ready;
   assign free             = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_ready);
   assign rsp_out_code     = code0_ff;
   assign rsp_out_run_last = cnt_ff == 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= codes.cnt;
      end else if (take) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code0_ff <= codes.code0;
         code1_ff <= codes.code1;
      end else if (take) begin
         code0_ff <= code1_ff;
      end
   end

endmodule

// File: rtl/utf8_to_gsm7_encoder.sv
// Top level of the UTF-8 to GSM 03.38 default alphabet encoder.
// Takes one UTF-8 byte per req_ word and gives zero, one or two GSM 7-bit codes on
// rsp_, rsp_out_run_last marking the final code caused by that byte. A byte enters an
// input register, is mapped by short logic against the open multi-byte group, and its
// codes land in a two-entry result register. A byte that maps to one code, or to none,
// passes at one word per cycle while rsp_ready holds; a byte that gives an escape pair (or
// a euro sign) holds the result register until both codes are taken, so the rate is set
// by the single code output port: one code per cycle while rsp_ready holds. in_last closes
// any open group; a cut-off group gives one '?'.
module utf8_to_gsm7_encoder import u2g_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_in_byte,
   input  logic             req_in_last,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [CodeW-1:0] rsp_out_code,
   output logic             rsp_out_run_last
);

   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       res_free;
   logic       advance;
   logic       load;
   codes_type  codes;

   // advance the input register into the result register once that one frees up
   assign advance   = in_vld_ff && res_free;
   // a word with no codes still advances, it just loads nothing
   assign load      = advance && (codes.cnt != 2'd0);
   assign req_ready = !in_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   // hold the payload while stalled
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
   end

   u2g_map u_map (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .codes   (codes)
   );

   u2g_outbuf u_outbuf (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .codes            (codes),
      .free             (res_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_code     (rsp_out_code),
      .rsp_out_run_last (rsp_out_run_last)
   );

endmodule
